### sv/assert_macros.svh
// assertion macros shared by the sampler rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

### sv/wsts_pkg.sv
// shared types and constants for the weighted sum-tree sampler
// no dependencies
package wsts_pkg;

	localparam int unsigned INDEX_W  = 6;
	localparam int unsigned WEIGHT_W = 32;
	localparam int unsigned TOTAL_W  = 40;

	localparam logic ACT_UPDATE = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	typedef struct packed {
		logic                       action;
		logic [INDEX_W-1:0]         entry_index;
		logic signed [WEIGHT_W-1:0] weight_change;
		logic [WEIGHT_W-1:0]        random_fraction;
	} req_t;

	typedef struct packed {
		logic [INDEX_W-1:0] chosen_index;
		logic [TOTAL_W-1:0] root_total;
		logic               saturated;
	} rsp_t;

endpackage

### sv/wsts_ram.sv
// single-port-write, single-port-read synchronous ram, read data registered
// no dependencies
module wsts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

### sv/weighted_sum_tree_sampler.sv
// weighted sum-tree sampler top level: heap of weights and subtree totals in two rams
// depends on wsts_pkg, wsts_ram and assert_macros.svh
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-------------------------------
//  request | req_valid | req_stall | req (action, index, change, fraction)
//  result  | rsp_valid | rsp_stall | rsp (chosen index, root total, saturated)
//
// update of a valid index: climbs from the entry to the root (depth 0), one ram read-modify-write per level
// sample: multiply, then one level per ram read down from the root, then result
// both limited by the single read port of each ram
// after reset a clearing pass writes zero to every entry, requests stalled
// one transaction in flight; the result register lets the next request in while rsp stalls
`include "assert_macros.svh"

module weighted_sum_tree_sampler #(
	parameter int ENTRIES = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  wsts_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output wsts_pkg::rsp_t rsp
);
	import wsts_pkg::*;

	localparam int IW = $clog2(ENTRIES);
	localparam logic [IW:0]   ENT_N  = (IW+1)'(ENTRIES);
	localparam logic [IW:0]   ENT_M1 = (IW+1)'(ENTRIES - 1);
	localparam logic [IW-1:0] LAST   = IW'(ENTRIES - 1);
	localparam logic [WEIGHT_W-1:0] W_MAX = '1;
	localparam logic [TOTAL_W-1:0]  T_MAX = '1;

	typedef enum logic [5:0] {
		ST_CLR  = 6'b000001,
		ST_IDLE = 6'b000010,
		ST_MUL  = 6'b000100,
		ST_WALK = 6'b001000,
		ST_UP   = 6'b010000,
		ST_FIN  = 6'b100000
	} state_t;

	state_t state_q;
	logic [IW-1:0]              clr_q;
	logic [IW-1:0]              node_q;
	logic                       first_q;
	logic                       sat_q;
	logic [INDEX_W-1:0]         chosen_q;
	logic signed [WEIGHT_W-1:0] change_q;
	logic [33:0]                applied_q;
	logic [TOTAL_W-1:0]         r_q;
	logic [63:0]                prod_lo_q;
	logic [TOTAL_W-1:0]         prod_hi_q;
	logic [TOTAL_W-1:0]         root_total_q;
	rsp_t                       rsp_q;
	logic                       rsp_valid_q;

	// ram ports
	logic                own_we, tot_we;
	logic [IW-1:0]       own_waddr, tot_waddr, own_raddr, tot_raddr;
	logic [WEIGHT_W-1:0] own_wdata, own_rdata;
	logic [TOTAL_W-1:0]  tot_wdata, tot_rdata;

	logic          accept, idx_ok, load_rsp;
	logic [IW-1:0] idx_node;

	// walk down
	logic [IW:0]          left_w, next_left_w;
	logic                 left_ok, right_ok, take_own, go_left, walk_done;
	logic [TOTAL_W-1:0]   left_tot, r_left, next_r;
	logic [TOTAL_W:0]     own_plus_left, r_right_w;
	logic [IW-1:0]        next_n;

	// walk up
	logic [33:0]          chg_ext, nw, appl_new, appl;
	logic                 nw_neg, nw_big, sat_w, t_sat;
	logic [WEIGHT_W-1:0]  nw_c;
	logic [41:0]          t_sum;
	logic [TOTAL_W-1:0]   t_c;
	logic [IW-1:0]        parent;

	wsts_ram #(.WIDTH(WEIGHT_W), .DEPTH(ENTRIES)) u_own_ram (
		.clk    (clk),
		.wr_en  (own_we),
		.wr_addr(own_waddr),
		.wr_data(own_wdata),
		.rd_addr(own_raddr),
		.rd_data(own_rdata)
	);

	wsts_ram #(.WIDTH(TOTAL_W), .DEPTH(ENTRIES)) u_tot_ram (
		.clk    (clk),
		.wr_en  (tot_we),
		.wr_addr(tot_waddr),
		.wr_data(tot_wdata),
		.rd_addr(tot_raddr),
		.rd_data(tot_rdata)
	);

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign idx_ok    = ({{(32-INDEX_W){1'b0}}, req.entry_index} < 32'(ENTRIES));
	assign idx_node  = IW'(req.entry_index);
	assign load_rsp  = (state_q == ST_FIN) && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// one level of the descent: own bucket, then left subtree, then right
	always_comb begin
		left_w        = {node_q, 1'b1};
		left_ok       = (left_w < ENT_N);
		right_ok      = (left_w < ENT_M1);
		left_tot      = left_ok ? tot_rdata : '0;
		take_own      = ({{(TOTAL_W-WEIGHT_W){1'b0}}, own_rdata} >= r_q);
		own_plus_left = {{(TOTAL_W-WEIGHT_W+1){1'b0}}, own_rdata} + {1'b0, left_tot};
		go_left       = left_ok && (own_plus_left >= {1'b0, r_q});
		r_left        = r_q - {{(TOTAL_W-WEIGHT_W){1'b0}}, own_rdata};
		r_right_w     = {1'b0, r_q} - own_plus_left;
		walk_done     = 1'b0;
		next_n        = node_q;
		next_r        = r_q;
		if (take_own) begin
			walk_done = 1'b1;
		end else if (go_left) begin
			next_n = IW'(left_w);
			next_r = r_left;
		end else if (right_ok) begin
			next_n = IW'(left_w + 1'b1);
			next_r = r_right_w[TOTAL_W-1:0];
		end else begin
			walk_done = 1'b1;
		end
		next_left_w = {next_n, 1'b1};
	end

	// one level of the climb: clip the weight once, then every total on the path
	always_comb begin
		chg_ext  = {{2{change_q[WEIGHT_W-1]}}, change_q};
		nw       = {2'b00, own_rdata} + chg_ext;
		nw_neg   = nw[33];
		nw_big   = !nw[33] && nw[32];
		sat_w    = nw_neg || nw_big;
		nw_c     = nw_neg ? '0 : (nw_big ? W_MAX : nw[WEIGHT_W-1:0]);
		appl_new = {2'b00, nw_c} - {2'b00, own_rdata};
		appl     = first_q ? appl_new : applied_q;
		t_sum    = {2'b00, tot_rdata} + {{8{appl[33]}}, appl};
		t_sat    = t_sum[41] || t_sum[40];
		t_c      = t_sum[41] ? '0 : (t_sum[40] ? T_MAX : t_sum[TOTAL_W-1:0]);
		parent   = (node_q - IW'(1)) >> 1;
	end

	always_comb begin
		case (state_q)
			ST_IDLE: begin
				own_raddr = (req.action == ACT_SAMPLE) ? '0 : idx_node;
				tot_raddr = (req.action == ACT_SAMPLE) ? IW'(1) : idx_node;
			end
			ST_MUL: begin
				own_raddr = '0;
				tot_raddr = IW'(1);
			end
			ST_WALK: begin
				own_raddr = next_n;
				tot_raddr = (next_left_w < ENT_N) ? IW'(next_left_w) : '0;
			end
			ST_UP: begin
				own_raddr = parent;
				tot_raddr = parent;
			end
			default: begin
				own_raddr = '0;
				tot_raddr = '0;
			end
		endcase
		own_we    = (state_q == ST_CLR) || ((state_q == ST_UP) && first_q);
		tot_we    = (state_q == ST_CLR) || (state_q == ST_UP);
		own_waddr = (state_q == ST_CLR) ? clr_q : node_q;
		tot_waddr = (state_q == ST_CLR) ? clr_q : node_q;
		own_wdata = (state_q == ST_CLR) ? '0 : nw_c;
		tot_wdata = (state_q == ST_CLR) ? '0 : t_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLR;
			clr_q        <= '0;
			rsp_valid_q  <= 1'b0;
			root_total_q <= '0;
		end else begin
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + IW'(1);
					if (clr_q == LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (req.action == ACT_SAMPLE) begin
							state_q <= ST_MUL;
						end else if (idx_ok) begin
							state_q <= ST_UP;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_MUL: begin
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (walk_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_UP: begin
					if (node_q == '0) begin
						root_total_q <= t_c;
						state_q      <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (load_rsp) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					chosen_q  <= req.entry_index;
					change_q  <= req.weight_change;
					node_q    <= idx_node;
					first_q   <= 1'b1;
					sat_q     <= 1'b0;
					// total split into high byte and low word, each times the fraction
					prod_lo_q <= 64'(root_total_q[31:0]) * 64'(req.random_fraction);
					prod_hi_q <= TOTAL_W'(root_total_q[TOTAL_W-1:32]) *
						TOTAL_W'(req.random_fraction);
				end
			end
			ST_MUL: begin
				r_q    <= prod_hi_q + TOTAL_W'(prod_lo_q[63:32]);
				node_q <= '0;
			end
			ST_WALK: begin
				node_q   <= next_n;
				r_q      <= next_r;
				chosen_q <= INDEX_W'(next_n);
			end
			ST_UP: begin
				first_q   <= 1'b0;
				applied_q <= appl;
				sat_q     <= sat_q || (first_q && sat_w) || t_sat;
				node_q    <= parent;
			end
			ST_FIN: begin
				if (load_rsp) begin
					rsp_q.chosen_index <= chosen_q;
					rsp_q.root_total   <= root_total_q;
					rsp_q.saturated    <= sat_q;
				end
			end
			default: begin
			end
		endcase
	end

	`ASSERT_IMPL(a_walk_node_in_range, clk, arst_n, state_q == ST_WALK, node_q <= LAST)
	`ASSERT_IMPL(a_sample_never_clips, clk, arst_n, state_q == ST_WALK, !sat_q)
	`ASSERT_NEXT(a_bad_index_skips_tree, clk, arst_n, accept && req.action == ACT_UPDATE && !idx_ok, state_q == ST_FIN)
	`ASSERT_NEXT(a_rsp_total_matches, clk, arst_n, load_rsp, rsp.root_total == root_total_q)

endmodule
